>>> rtl/core/wsht_pkg.sv
// wsht_pkg: shared types, codes and helpers of the window stack hit-test engine
// no dependencies; used by the controller, the datapath, the top level and the checker
package wsht_pkg;

   localparam int NumWindowsDefault = 16;

   localparam int CmdW   = 3;
   localparam int SlotW  = 4;
   localparam int CoordW = 12;
   localparam int StatW  = 2;
   localparam int CountW = 5;
   localparam int GrabW  = 13;
   localparam int CsrIdxW = 1;

   localparam int TitleH     = 12;
   localparam int CloseInset = 16;
   localparam int CloseW     = 14;
   localparam int CloseH     = 10;
   localparam int CloseDy    = 2;

   localparam logic [CoordW-1:0] ScreenWidthReset  = 12'd1024;
   localparam logic [CoordW-1:0] ScreenHeightReset = 12'd768;

   // command codes
   localparam logic [CmdW-1:0] CMD_CREATE     = 3'd0;
   localparam logic [CmdW-1:0] CMD_FIND       = 3'd1;
   localparam logic [CmdW-1:0] CMD_RAISE      = 3'd2;
   localparam logic [CmdW-1:0] CMD_CLOSE      = 3'd3;
   localparam logic [CmdW-1:0] CMD_DRAG_START = 3'd4;
   localparam logic [CmdW-1:0] CMD_DRAG_MOVE  = 3'd5;
   localparam logic [CmdW-1:0] CMD_DRAG_STOP  = 3'd6;
   localparam logic [CmdW-1:0] CMD_UNUSED     = 3'd7;

   // result status codes
   localparam logic [StatW-1:0] STAT_OK   = 2'd0;
   localparam logic [StatW-1:0] STAT_FULL = 2'd1;
   localparam logic [StatW-1:0] STAT_NONE = 2'd2;

   // configuration register indexes
   localparam logic [CsrIdxW-1:0] CSR_SCREEN_WIDTH  = 1'b0;
   localparam logic [CsrIdxW-1:0] CSR_SCREEN_HEIGHT = 1'b1;

   // datapath operations, one per cycle
   typedef enum logic [3:0] {
      OP_NONE,
      OP_CREATE,
      OP_RES_FULL,
      OP_RES_FAIL,
      OP_F_INIT,
      OP_F_ORD,
      OP_F_SLT,
      OP_F_CHK,
      OP_S_RD,
      OP_S_ACT,
      OP_P_RD,
      OP_P_NEXT,
      OP_SH_RD,
      OP_SH_WR,
      OP_P_FIN,
      OP_PUBLISH
   } dp_op_type;

   typedef struct packed {
      logic      load;
      dp_op_type op;
   } ctl_cmd_type;

   typedef struct packed {
      logic [CmdW-1:0] cmd;
      logic            full;
      logic            slot_ok;
      logic            idx_zero;
      logic            hit;
      logic            match;
      logic            shift_more;
      logic            rsp_busy;
   } dp_stat_type;

   typedef struct packed {
      logic [CoordW-1:0] left;
      logic [CoordW-1:0] top;
      logic [CoordW-1:0] width;
      logic [CoordW-1:0] height;
      logic [GrabW-1:0]  gdx;
      logic [GrabW-1:0]  gdy;
   } slot_rec_type;

   // keep one axis of a dragged window inside the screen
   function automatic logic [CoordW-1:0] clamp_axis(input logic signed [14:0] p,
                                                    input logic [CoordW-1:0] size,
                                                    input logic [CoordW-1:0] scr);
      logic signed [14:0] q;
      logic signed [14:0] s;
      logic signed [14:0] c;
      s = signed'({3'b000, size});
      c = signed'({3'b000, scr});
      q = (p < 15'sd0) ? 15'sd0 : p;
      if (q + s > c) begin
         q = (s > c) ? 15'sd0 : (c - s);
      end
      return q[CoordW-1:0];
   endfunction

endpackage

>>> rtl/core/wsht_ctrl.sv
// wsht_ctrl: command sequencer of the window stack hit-test engine
// depends on wsht_pkg; drives wsht_dpath through ctl_cmd_type
module wsht_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  wsht_pkg::dp_stat_type stat,
   output wsht_pkg::ctl_cmd_type ctl
);

   typedef enum logic [11:0] {
      ST_IDLE  = 12'b000000000001,
      ST_DISP  = 12'b000000000010,
      ST_F_ORD = 12'b000000000100,
      ST_F_SLT = 12'b000000001000,
      ST_F_CHK = 12'b000000010000,
      ST_S_ACT = 12'b000000100000,
      ST_P_RD  = 12'b000001000000,
      ST_P_CHK = 12'b000010000000,
      ST_SH_CK = 12'b000100000000,
      ST_SH_RD = 12'b001000000000,
      ST_SH_WR = 12'b010000000000,
      ST_DONE  = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      ctl.load = 1'b0;
      ctl.op   = wsht_pkg::OP_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctl.load = 1'b1;
               state_in = ST_DISP;
            end
         end
         ST_DISP: begin
            case (stat.cmd)
               wsht_pkg::CMD_CREATE: begin
                  ctl.op   = stat.full ? wsht_pkg::OP_RES_FULL : wsht_pkg::OP_CREATE;
                  state_in = ST_DONE;
               end
               wsht_pkg::CMD_FIND: begin
                  ctl.op   = wsht_pkg::OP_F_INIT;
                  state_in = ST_F_ORD;
               end
               wsht_pkg::CMD_UNUSED: begin
                  ctl.op   = wsht_pkg::OP_RES_FAIL;
                  state_in = ST_DONE;
               end
               default: begin
                  if (stat.slot_ok) begin
                     ctl.op   = wsht_pkg::OP_S_RD;
                     state_in = ST_S_ACT;
                  end else begin
                     ctl.op   = wsht_pkg::OP_RES_FAIL;
                     state_in = ST_DONE;
                  end
               end
            endcase
         end
         ST_F_ORD: begin
            if (stat.idx_zero) begin
               ctl.op   = wsht_pkg::OP_RES_FAIL;
               state_in = ST_DONE;
            end else begin
               ctl.op   = wsht_pkg::OP_F_ORD;
               state_in = ST_F_SLT;
            end
         end
         ST_F_SLT: begin
            ctl.op   = wsht_pkg::OP_F_SLT;
            state_in = ST_F_CHK;
         end
         ST_F_CHK: begin
            ctl.op   = wsht_pkg::OP_F_CHK;
            state_in = stat.hit ? ST_DONE : ST_F_ORD;
         end
         ST_S_ACT: begin
            ctl.op = wsht_pkg::OP_S_ACT;
            if (stat.cmd == wsht_pkg::CMD_RAISE || stat.cmd == wsht_pkg::CMD_CLOSE) begin
               state_in = ST_P_RD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_P_RD: begin
            ctl.op   = wsht_pkg::OP_P_RD;
            state_in = ST_P_CHK;
         end
         ST_P_CHK: begin
            if (stat.match) begin
               state_in = ST_SH_CK;
            end else begin
               ctl.op   = wsht_pkg::OP_P_NEXT;
               state_in = ST_P_RD;
            end
         end
         ST_SH_CK: begin
            if (stat.shift_more) begin
               state_in = ST_SH_RD;
            end else begin
               ctl.op   = wsht_pkg::OP_P_FIN;
               state_in = ST_DONE;
            end
         end
         ST_SH_RD: begin
            ctl.op   = wsht_pkg::OP_SH_RD;
            state_in = ST_SH_WR;
         end
         ST_SH_WR: begin
            ctl.op   = wsht_pkg::OP_SH_WR;
            state_in = ST_SH_CK;
         end
         ST_DONE: begin
            if (!stat.rsp_busy) begin
               ctl.op   = wsht_pkg::OP_PUBLISH;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/core/wsht_dpath.sv
// wsht_dpath: window table, stacking order, hit test, drag math and result register
// depends on wsht_pkg; sequenced by wsht_ctrl
module wsht_dpath #(
   parameter int NUM_WINDOWS = wsht_pkg::NumWindowsDefault
) (
   input  logic                             clock,
   input  logic                             reset,
   input  wsht_pkg::ctl_cmd_type            ctl,
   output wsht_pkg::dp_stat_type            stat,
   input  logic [wsht_pkg::CmdW-1:0]        req_command,
   input  logic [wsht_pkg::SlotW-1:0]       req_slot,
   input  logic [wsht_pkg::CoordW-1:0]      req_pos_x,
   input  logic [wsht_pkg::CoordW-1:0]      req_pos_y,
   input  logic [wsht_pkg::CoordW-1:0]      req_size_w,
   input  logic [wsht_pkg::CoordW-1:0]      req_size_h,
   input  logic                             csr_we,
   input  logic [wsht_pkg::CsrIdxW-1:0]     csr_index,
   input  logic [wsht_pkg::CoordW-1:0]      csr_wdata,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [wsht_pkg::StatW-1:0]       rsp_status,
   output logic [wsht_pkg::SlotW-1:0]       rsp_result_slot,
   output logic                             rsp_in_title_bar,
   output logic                             rsp_on_close_box,
   output logic [wsht_pkg::CoordW-1:0]      rsp_win_left,
   output logic [wsht_pkg::CoordW-1:0]      rsp_win_top,
   output logic [wsht_pkg::CountW-1:0]      rsp_open_count
);

   localparam int SW = (NUM_WINDOWS > 1) ? $clog2(NUM_WINDOWS) : 1;
   localparam int LW = $clog2(NUM_WINDOWS + 1);
   localparam int CW = wsht_pkg::CoordW;

   // request
   logic [wsht_pkg::CmdW-1:0]  cmd_ff;
   logic [wsht_pkg::SlotW-1:0] slot_ff;
   logic [CW-1:0]              px_ff, py_ff, sw_ff, sh_ff;

   // configuration
   logic [CW-1:0] scr_w_ff, scr_h_ff;

   // per-slot flags, stack length, walk index
   logic [NUM_WINDOWS-1:0] shown_ff, shown_in;
   logic [NUM_WINDOWS-1:0] drag_ff, drag_in;
   logic [LW-1:0]          len_ff, len_in;
   logic [LW-1:0]          idx_ff, idx_in;
   logic [SW-1:0]          cur_ff, cur_in;

   // memories
   wsht_pkg::slot_rec_type mem_slot [NUM_WINDOWS];
   wsht_pkg::slot_rec_type slot_rd_ff, slot_wd;
   logic [SW-1:0]          slot_ra, slot_wa;
   logic                   slot_we;
   logic [SW-1:0]          mem_order [NUM_WINDOWS];
   logic [SW-1:0]          order_rd_ff, order_wd, order_ra, order_wa;
   logic                   order_we;

   // pending result
   logic [wsht_pkg::StatW-1:0] res_stat_ff, res_stat_in;
   logic [wsht_pkg::SlotW-1:0] res_slot_ff, res_slot_in;
   logic                       res_title_ff, res_title_in;
   logic                       res_close_ff, res_close_in;
   logic [CW-1:0]              res_left_ff, res_left_in;
   logic [CW-1:0]              res_top_ff, res_top_in;

   // response register
   logic                        rsp_valid_ff;
   logic [wsht_pkg::StatW-1:0]  rsp_stat_ff;
   logic [wsht_pkg::SlotW-1:0]  rsp_slot_ff;
   logic                        rsp_title_ff, rsp_close_ff;
   logic [CW-1:0]               rsp_left_ff, rsp_top_ff;
   logic [wsht_pkg::CountW-1:0] rsp_count_ff;

   logic [SW-1:0] sidx;
   logic [SW-1:0] free_idx;
   logic          slot_ok;

   // hit test
   logic signed [14:0] hx, hy, hw, hh, mx, my, hxr, hbx;
   logic               in_rect, hit, title, closeb;

   // drag math
   logic signed [14:0] nx, ny;
   logic [CW-1:0]      new_left, new_top;

   assign sidx    = SW'(slot_ff);
   assign slot_ok = (32'(slot_ff) < NUM_WINDOWS) && shown_ff[sidx];

   // first free slot, last slot when every other one is taken
   always_comb begin
      free_idx = SW'(NUM_WINDOWS - 1);
      for (int i = NUM_WINDOWS - 2; i >= 0; i--) begin
         if (!shown_ff[i]) begin
            free_idx = SW'(i);
         end
      end
   end

   always_comb begin
      hx  = signed'({3'b000, slot_rd_ff.left});
      hy  = signed'({3'b000, slot_rd_ff.top});
      hw  = signed'({3'b000, slot_rd_ff.width});
      hh  = signed'({3'b000, slot_rd_ff.height});
      mx  = signed'({3'b000, px_ff});
      my  = signed'({3'b000, py_ff});
      hxr = hx + hw;
      hbx = hxr - 15'(wsht_pkg::CloseInset);
      in_rect = (mx >= hx) && (mx < hxr) && (my >= hy) && (my < hy + hh);
      hit     = in_rect && shown_ff[cur_ff];
      title   = (mx < hbx) && (my < hy + 15'(wsht_pkg::TitleH));
      closeb  = (mx >= hbx) && (mx < hbx + 15'(wsht_pkg::CloseW)) &&
                (my >= hy + 15'(wsht_pkg::CloseDy)) &&
                (my < hy + 15'(wsht_pkg::CloseDy + wsht_pkg::CloseH));
   end

   always_comb begin
      nx = signed'({3'b000, px_ff}) - signed'({{2{slot_rd_ff.gdx[12]}}, slot_rd_ff.gdx});
      ny = signed'({3'b000, py_ff}) - signed'({{2{slot_rd_ff.gdy[12]}}, slot_rd_ff.gdy});
      new_left = wsht_pkg::clamp_axis(nx, slot_rd_ff.width, scr_w_ff);
      new_top  = wsht_pkg::clamp_axis(ny, slot_rd_ff.height, scr_h_ff);
   end

   always_comb begin
      shown_in     = shown_ff;
      drag_in      = drag_ff;
      len_in       = len_ff;
      idx_in       = idx_ff;
      cur_in       = cur_ff;
      res_stat_in  = res_stat_ff;
      res_slot_in  = res_slot_ff;
      res_title_in = res_title_ff;
      res_close_in = res_close_ff;
      res_left_in  = res_left_ff;
      res_top_in   = res_top_ff;
      slot_ra  = sidx;
      slot_wa  = sidx;
      slot_we  = 1'b0;
      slot_wd  = slot_rd_ff;
      order_ra = SW'(idx_ff);
      order_wa = SW'(idx_ff);
      order_we = 1'b0;
      order_wd = order_rd_ff;
      case (ctl.op)
         wsht_pkg::OP_CREATE: begin
            slot_we  = 1'b1;
            slot_wa  = free_idx;
            slot_wd  = '{left: px_ff, top: py_ff, width: sw_ff, height: sh_ff,
                         gdx: '0, gdy: '0};
            order_we = 1'b1;
            order_wa = SW'(len_ff);
            order_wd = free_idx;
            shown_in[free_idx] = 1'b1;
            drag_in[free_idx]  = 1'b0;
            len_in       = len_ff + LW'(1);
            res_stat_in  = wsht_pkg::STAT_OK;
            res_slot_in  = wsht_pkg::SlotW'(free_idx);
            res_title_in = 1'b0;
            res_close_in = 1'b0;
            res_left_in  = px_ff;
            res_top_in   = py_ff;
         end
         wsht_pkg::OP_RES_FULL: begin
            res_stat_in  = wsht_pkg::STAT_FULL;
            res_slot_in  = '0;
            res_title_in = 1'b0;
            res_close_in = 1'b0;
            res_left_in  = '0;
            res_top_in   = '0;
         end
         wsht_pkg::OP_RES_FAIL: begin
            res_stat_in  = wsht_pkg::STAT_NONE;
            res_slot_in  = (cmd_ff == wsht_pkg::CMD_FIND || cmd_ff == wsht_pkg::CMD_UNUSED) ?
                           '0 : slot_ff;
            res_title_in = 1'b0;
            res_close_in = 1'b0;
            res_left_in  = '0;
            res_top_in   = '0;
         end
         wsht_pkg::OP_F_INIT: begin
            idx_in = len_ff;
         end
         wsht_pkg::OP_F_ORD: begin
            order_ra = SW'(idx_ff - LW'(1));
            idx_in   = idx_ff - LW'(1);
         end
         wsht_pkg::OP_F_SLT: begin
            cur_in  = order_rd_ff;
            slot_ra = order_rd_ff;
         end
         wsht_pkg::OP_F_CHK: begin
            if (hit) begin
               res_stat_in  = wsht_pkg::STAT_OK;
               res_slot_in  = wsht_pkg::SlotW'(cur_ff);
               res_title_in = title;
               res_close_in = closeb;
               res_left_in  = slot_rd_ff.left;
               res_top_in   = slot_rd_ff.top;
            end
         end
         wsht_pkg::OP_S_RD: begin
            slot_ra = sidx;
         end
         wsht_pkg::OP_S_ACT: begin
            res_stat_in  = wsht_pkg::STAT_OK;
            res_slot_in  = slot_ff;
            res_title_in = 1'b0;
            res_close_in = 1'b0;
            res_left_in  = slot_rd_ff.left;
            res_top_in   = slot_rd_ff.top;
            idx_in       = '0;
            case (cmd_ff)
               wsht_pkg::CMD_DRAG_START: begin
                  drag_in[sidx] = 1'b1;
                  slot_we     = 1'b1;
                  slot_wd.gdx = wsht_pkg::GrabW'({1'b0, px_ff}) -
                                wsht_pkg::GrabW'({1'b0, slot_rd_ff.left});
                  slot_wd.gdy = wsht_pkg::GrabW'({1'b0, py_ff}) -
                                wsht_pkg::GrabW'({1'b0, slot_rd_ff.top});
               end
               wsht_pkg::CMD_DRAG_MOVE: begin
                  if (drag_ff[sidx]) begin
                     slot_we      = 1'b1;
                     slot_wd.left = new_left;
                     slot_wd.top  = new_top;
                     res_left_in  = new_left;
                     res_top_in   = new_top;
                  end
               end
               wsht_pkg::CMD_DRAG_STOP: begin
                  drag_in[sidx] = 1'b0;
               end
               default: begin
               end
            endcase
         end
         wsht_pkg::OP_P_RD: begin
            order_ra = SW'(idx_ff);
         end
         wsht_pkg::OP_P_NEXT: begin
            idx_in = idx_ff + LW'(1);
         end
         wsht_pkg::OP_SH_RD: begin
            order_ra = SW'(idx_ff + LW'(1));
         end
         wsht_pkg::OP_SH_WR: begin
            order_we = 1'b1;
            order_wa = SW'(idx_ff);
            order_wd = order_rd_ff;
            idx_in   = idx_ff + LW'(1);
         end
         wsht_pkg::OP_P_FIN: begin
            if (cmd_ff == wsht_pkg::CMD_RAISE) begin
               order_we = 1'b1;
               order_wa = SW'(len_ff - LW'(1));
               order_wd = sidx;
            end else begin
               len_in        = len_ff - LW'(1);
               shown_in[sidx] = 1'b0;
               drag_in[sidx]  = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      stat.cmd        = cmd_ff;
      stat.full       = (32'(len_ff) >= NUM_WINDOWS);
      stat.slot_ok    = slot_ok;
      stat.idx_zero   = (idx_ff == '0);
      stat.hit        = hit;
      stat.match      = (order_rd_ff == sidx);
      stat.shift_more = ({1'b0, idx_ff} + (LW+1)'(1)) < {1'b0, len_ff};
      stat.rsp_busy   = rsp_valid_ff && !rsp_ready;
   end

   // memories
   always_ff @(posedge clock) begin
      if (slot_we) begin
         mem_slot[slot_wa] <= slot_wd;
      end
      slot_rd_ff <= mem_slot[slot_ra];
   end

   always_ff @(posedge clock) begin
      if (order_we) begin
         mem_order[order_wa] <= order_wd;
      end
      order_rd_ff <= mem_order[order_ra];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         shown_ff     <= '0;
         drag_ff      <= '0;
         len_ff       <= '0;
         scr_w_ff     <= wsht_pkg::ScreenWidthReset;
         scr_h_ff     <= wsht_pkg::ScreenHeightReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         shown_ff <= shown_in;
         drag_ff  <= drag_in;
         len_ff   <= len_in;
         if (csr_we && csr_index == wsht_pkg::CSR_SCREEN_WIDTH) begin
            scr_w_ff <= csr_wdata;
         end
         if (csr_we && csr_index == wsht_pkg::CSR_SCREEN_HEIGHT) begin
            scr_h_ff <= csr_wdata;
         end
         if (ctl.op == wsht_pkg::OP_PUBLISH) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      cur_ff       <= cur_in;
      res_stat_ff  <= res_stat_in;
      res_slot_ff  <= res_slot_in;
      res_title_ff <= res_title_in;
      res_close_ff <= res_close_in;
      res_left_ff  <= res_left_in;
      res_top_ff   <= res_top_in;
      if (ctl.load) begin
         cmd_ff  <= req_command;
         slot_ff <= req_slot;
         px_ff   <= req_pos_x;
         py_ff   <= req_pos_y;
         sw_ff   <= req_size_w;
         sh_ff   <= req_size_h;
      end
      if (ctl.op == wsht_pkg::OP_PUBLISH) begin
         rsp_stat_ff  <= res_stat_ff;
         rsp_slot_ff  <= res_slot_ff;
         rsp_title_ff <= res_title_ff;
         rsp_close_ff <= res_close_ff;
         rsp_left_ff  <= res_left_ff;
         rsp_top_ff   <= res_top_ff;
         rsp_count_ff <= wsht_pkg::CountW'(len_ff);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_stat_ff;
   assign rsp_result_slot  = rsp_slot_ff;
   assign rsp_in_title_bar = rsp_title_ff;
   assign rsp_on_close_box = rsp_close_ff;
   assign rsp_win_left     = rsp_left_ff;
   assign rsp_win_top      = rsp_top_ff;
   assign rsp_open_count   = rsp_count_ff;

endmodule

>>> rtl/core/window_stack_hit_test_engine.sv
// window_stack_hit_test_engine: top level, controller plus datapath
// depends on wsht_pkg, wsht_ctrl and wsht_dpath
//
// usage
//  - req channel (valid/ready): one command beat carries command, slot, pos and size;
//    create, find, raise, close, drag start, drag move, drag stop
//  - rsp channel (valid/ready): exactly one result beat per command, in order
//  - csr port: write-only, index 0 screen width, index 1 screen height (drag clamp);
//    write only while the block is idle
//  - find walks the stacking order from the top entry down and stops at the first hit;
//    raise and close search the order from the bottom for the slot, shift every entry
//    above it down by one, then raise puts the slot on top and close drops it
//  - the find walk reads one entry of the order memory and one window record per
//    step, the raise and close walk reads order entries only; each read is registered
//  - one command is in work at a time; req_ready is high only while the sequencer idles
//  - results sit in an output register, so the next command is accepted while
//    an earlier result still waits; a stalled rsp only holds a finished command
//  - reset: empty stack, every slot free, screen 1024 by 768, no clearing pass
module window_stack_hit_test_engine #(
   parameter int NUM_WINDOWS = wsht_pkg::NumWindowsDefault
) (
   input  logic                             clock,
   input  logic                             reset,
   // command channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [wsht_pkg::CmdW-1:0]        req_command,
   input  logic [wsht_pkg::SlotW-1:0]       req_slot,
   input  logic [wsht_pkg::CoordW-1:0]      req_pos_x,
   input  logic [wsht_pkg::CoordW-1:0]      req_pos_y,
   input  logic [wsht_pkg::CoordW-1:0]      req_size_w,
   input  logic [wsht_pkg::CoordW-1:0]      req_size_h,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [wsht_pkg::StatW-1:0]       rsp_status,
   output logic [wsht_pkg::SlotW-1:0]       rsp_result_slot,
   output logic                             rsp_in_title_bar,
   output logic                             rsp_on_close_box,
   output logic [wsht_pkg::CoordW-1:0]      rsp_win_left,
   output logic [wsht_pkg::CoordW-1:0]      rsp_win_top,
   output logic [wsht_pkg::CountW-1:0]      rsp_open_count,
   // configuration
   input  logic                             csr_we,
   input  logic [wsht_pkg::CsrIdxW-1:0]     csr_index,
   input  logic [wsht_pkg::CoordW-1:0]      csr_wdata
);

   wsht_pkg::ctl_cmd_type ctl;
   wsht_pkg::dp_stat_type stat;

   // sequencer: walks the stack one step per state
   wsht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   // storage, compare and clamp logic, output register
   wsht_dpath #(
      .NUM_WINDOWS (NUM_WINDOWS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .stat             (stat),
      .req_command      (req_command),
      .req_slot         (req_slot),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_size_w       (req_size_w),
      .req_size_h       (req_size_h),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_result_slot  (rsp_result_slot),
      .rsp_in_title_bar (rsp_in_title_bar),
      .rsp_on_close_box (rsp_on_close_box),
      .rsp_win_left     (rsp_win_left),
      .rsp_win_top      (rsp_win_top),
      .rsp_open_count   (rsp_open_count)
   );

endmodule

>>> rtl/core/wsht_checker.sv
// wsht_checker: port-level assertions for the window stack hit-test engine
// depends on wsht_pkg; bound to window_stack_hit_test_engine
module wsht_checker #(
   parameter int NUM_WINDOWS = wsht_pkg::NumWindowsDefault
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [wsht_pkg::StatW-1:0]  rsp_status,
   input logic                        rsp_in_title_bar,
   input logic                        rsp_on_close_box,
   input logic [wsht_pkg::CountW-1:0] rsp_open_count
);

   // a stalled result beat stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp beat dropped while stalled");

   // one command at a time: busy right after an accept
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("command accepted while busy");

   // table full only when the stack holds every slot
   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == wsht_pkg::STAT_FULL |->
         rsp_open_count == wsht_pkg::CountW'(NUM_WINDOWS))
      else $error("table full with free slots");

   // hit flags only on a successful find, never both
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_in_title_bar || rsp_on_close_box) |->
         rsp_status == wsht_pkg::STAT_OK && !(rsp_in_title_bar && rsp_on_close_box))
      else $error("bad hit flags");

   // status codes stay within the defined set
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == wsht_pkg::STAT_OK || rsp_status == wsht_pkg::STAT_FULL ||
                    rsp_status == wsht_pkg::STAT_NONE)
      else $error("undefined status code");

endmodule

bind window_stack_hit_test_engine wsht_checker #(
   .NUM_WINDOWS (NUM_WINDOWS)
) u_wsht_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_status       (rsp_status),
   .rsp_in_title_bar (rsp_in_title_bar),
   .rsp_on_close_box (rsp_on_close_box),
   .rsp_open_count   (rsp_open_count)
);
